>>> sv/deq_pkg.sv
// shared command codes, status codes, field widths and controller/datapath signal groups
package deq_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // field widths of the stream payloads
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // controller to datapath
  typedef struct packed {
    logic load;       // request accepted this cycle
    logic take_read;  // capture read data from the store
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_read; // current request reads an entry
  } deq_stat_t;

endpackage

>>> sv/deq_ram.sv
// generic single-write, single-read memory with registered read data
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/deq_ctrl.sv
// request sequencer: accept, optional store read, result hand-off
module deq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  deq_pkg::deq_stat_t stat_i,
  output deq_pkg::deq_cmd_t  cmd_o
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.needs_read ? S_READ : S_RESP;
        end
      end
      S_READ: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // handshakes and datapath commands
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = (state_q == S_RESP);
  assign cmd_o.load      = in_ready_o && in_valid_i;
  assign cmd_o.take_read = (state_q == S_READ);

endmodule

>>> sv/deq_datapath.sv
// ring pointers, entry count, entry store and result registers
module deq_datapath #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  deq_pkg::deq_cmd_t            cmd_i,
  output deq_pkg::deq_stat_t           stat_o,
  input  logic [deq_pkg::CMD_W-1:0]    req_cmd_i,
  input  logic [deq_pkg::VALUE_W-1:0]  push_value_i,
  output logic [deq_pkg::VALUE_W-1:0] read_value_o,
  output logic [deq_pkg::STAT_W-1:0]   status_o,
  output logic                         is_empty_o,
  output logic [deq_pkg::FILL_W-1:0]   fill_count_o
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S     = SW'(CAPACITY);

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0] read_value_q;

  logic is_push, is_pop, is_front_read, is_read;
  logic full, empty, push_ok, read_ok;
  logic [AW-1:0] front_inc, front_dec;
  logic [SW-1:0] tail_sum, back_sum;
  logic [AW-1:0] tail_slot, back_slot;

  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [DATA_WIDTH+VALUE_W-1:0] wr_ext, rd_ext;
  logic [CW+FILL_W-1:0] fill_ext;

  // command decode
  assign is_push = (req_cmd_i == CMD_PUSH_FRONT) || (req_cmd_i == CMD_PUSH_BACK);
  assign is_pop  = (req_cmd_i == CMD_POP_FRONT) || (req_cmd_i == CMD_POP_BACK);
  assign is_front_read = (req_cmd_i == CMD_POP_FRONT) || (req_cmd_i == CMD_PEEK_FRONT);
  assign is_read = is_pop || is_front_read
                   || (req_cmd_i == CMD_PEEK_BACK);

  assign full    = (count_q == CAP_C);
  assign empty   = (count_q == '0);
  assign push_ok = is_push && !full;
  assign read_ok = is_read && !empty;

  assign stat_o.needs_read = read_ok;

  // ring index arithmetic, sums stay below twice the capacity
  assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
  assign tail_sum  = SW'(front_q) + SW'(count_q);
  assign back_sum  = tail_sum - 1'b1;
  assign tail_slot = (tail_sum >= CAP_S) ? AW'(tail_sum - CAP_S) : AW'(tail_sum);
  assign back_slot = (back_sum >= CAP_S) ? AW'(back_sum - CAP_S) : AW'(back_sum);

  // store ports
  assign wr_ext    = {{DATA_WIDTH{1'b0}}, push_value_i};
  assign ram_wdata = wr_ext[DATA_WIDTH-1:0];
  assign ram_waddr = (req_cmd_i == CMD_PUSH_FRONT) ? front_dec : tail_slot;
  assign ram_raddr = is_front_read ? front_q : back_slot;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && push_ok),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load && read_ok),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // pointer, count and status update
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = ST_OK;
    if (is_push) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
        if (req_cmd_i == CMD_PUSH_FRONT) begin
          front_d = front_dec;
        end
      end
    end else if (is_read) begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else if (is_pop) begin
        count_d = count_q - 1'b1;
        if (req_cmd_i == CMD_POP_FRONT) begin
          front_d = front_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.load) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // result registers
  assign rd_ext = {{VALUE_W{1'b0}}, ram_rdata};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q     <= status_d;
      read_value_q <= '0;
    end else if (cmd_i.take_read) begin
      read_value_q <= rd_ext[VALUE_W-1:0];
    end
  end

  assign fill_ext     = {{FILL_W{1'b0}}, count_q};
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign is_empty_o   = empty;
  assign fill_count_o = fill_ext[FILL_W-1:0];

endmodule

>>> sv/double_ended_queue_core.sv
// bounded double-ended queue on a ring buffer, top level
//
//   channel   dir   payload
//   s_axis    in    tdata[2:0] cmd, [34:3] push_value, [39:35] zero
//   m_axis    out   tdata[31:0] read_value, [33:32] status, [34] is_empty,
//                   [39:35] fill_count
//
// a push or an error goes straight to the result; a pop or peek that finds an
// entry first passes the read state for the registered read of the entry store
// one request is in flight at a time; s_axis_tready is low until its result
// has been taken on m_axis, so a stalled result holds off the next request
// reset clears the front index and count; store contents need no clearing
module double_ended_queue_core #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // cmd [2:0], push_value [34:3], zero fill [39:35]
  input  logic [deq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_value [31:0], status [33:32], is_empty [34], fill_count [39:35]
  output logic [deq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import deq_pkg::*;

  deq_cmd_t  dp_cmd;
  deq_stat_t dp_stat;

  logic [VALUE_W-1:0] read_value;
  logic [STAT_W-1:0]  status;
  logic               is_empty;
  logic [FILL_W-1:0]  fill_count;

  // sequencer
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // pointers, store and results
  deq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .req_cmd_i    (s_axis_tdata[CMD_W-1:0]),
    .push_value_i (s_axis_tdata[CMD_W+VALUE_W-1:CMD_W]),
    .read_value_o (read_value),
    .status_o     (status),
    .is_empty_o   (is_empty),
    .fill_count_o (fill_count)
  );

  // result packing
  assign m_axis_tdata = {fill_count, is_empty, status, read_value};

endmodule

>>> tb/double_ended_queue_core_tb.sv
// self-checking testbench for double_ended_queue_core: directed table, then biased random requests
module double_ended_queue_core_tb;
  import deq_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned RANDOM_REQUESTS = 850;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 10;

  // command codes the block does not use: no state change, status ok
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // random phase kinds
  localparam int unsigned PHASE_FILL  = 0;
  localparam int unsigned PHASE_DRAIN = 1;
  localparam int unsigned PHASE_MIXED = 2;

  // reply layout matches m_axis_tdata from the top bit down
  typedef struct packed {
    logic [FILL_W-1:0]  fill_count;
    logic               is_empty;
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] read_value;
  } deq_reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic               typed;
    deq_reply_t         want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // cmd [2:0], push_value [34:3], zero fill [39:35]
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // read_value [31:0], status [33:32], is_empty [34], fill_count [39:35]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // shadow copy of the deque contents
  logic [VALUE_W-1:0] shadow_store [CAPACITY];
  logic [3:0]         shadow_front;
  logic [FILL_W-1:0]  shadow_count;

  deq_reply_t  pending_replies [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_count;
  bit          idle_on;

  double_ended_queue_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (VALUE_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // applies one request to the shadow deque and returns the reply it should give
  function automatic deq_reply_t deque_apply(input logic [CMD_W-1:0] cmd,
                                             input logic [VALUE_W-1:0] value);
    deq_reply_t r;
    logic [3:0] slot;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            shadow_front = shadow_front - 4'd1;
            slot = shadow_front;
          end else begin
            slot = shadow_front + shadow_count[3:0];
          end
          shadow_store[slot] = value;
          shadow_count = shadow_count + 5'd1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT) begin
          r.read_value = shadow_store[shadow_front];
          if (cmd == CMD_POP_FRONT) begin
            shadow_front = shadow_front + 4'd1;
            shadow_count = shadow_count - 5'd1;
          end
        end else begin
          // back entry sits count-1 slots past the front, modulo the ring
          slot = shadow_front + shadow_count[3:0] - 4'd1;
          r.read_value = shadow_store[slot];
          if (cmd == CMD_POP_BACK) begin
            shadow_count = shadow_count - 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
    r.is_empty = (shadow_count == 0);
    r.fill_count = shadow_count;
    return r;
  endfunction

  function automatic deq_reply_t make_reply(input logic [VALUE_W-1:0] read_value,
                                            input logic [STAT_W-1:0] status,
                                            input logic is_empty,
                                            input logic [FILL_W-1:0] fill_count);
    deq_reply_t r;
    r.read_value = read_value;
    r.status = status;
    r.is_empty = is_empty;
    r.fill_count = fill_count;
    return r;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                         input logic typed, input deq_reply_t want);
    stim_row_t row;
    row.cmd = cmd;
    row.value = value;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // command mix depends on the phase so the deque swings between empty and full
  function automatic logic [CMD_W-1:0] pick_command(input int unsigned push_pct);
    int unsigned r;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      cmd = r[0] ? CMD_SPARE_7 : CMD_SPARE_6;
    end else if (r < 3 + push_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else if (r < 85) begin
      cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end else begin
      cmd = $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
    end
    return cmd;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    logic [VALUE_W-1:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // drive one request, optionally after an idle burst, and log its reply once accepted
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                              input logic typed, input deq_reply_t want);
    int unsigned gap;
    deq_reply_t predicted;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - CMD_W - VALUE_W){1'b0}}, value, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = deque_apply(cmd, value);
    pending_replies.push_back(typed ? want : predicted);
  endtask

  task automatic check_reply(input deq_reply_t got);
    deq_reply_t want;
    if (pending_replies.size() == 0) begin
      flag_mismatch("reply with no request pending", got.read_value, '0);
      return;
    end
    want = pending_replies.pop_front();
    if (got.read_value !== want.read_value)
      flag_mismatch("read_value", got.read_value, want.read_value);
    if (got.status !== want.status)
      flag_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
    if (got.is_empty !== want.is_empty)
      flag_mismatch("is_empty", VALUE_W'(got.is_empty), VALUE_W'(want.is_empty));
    if (got.fill_count !== want.fill_count)
      flag_mismatch("fill_count", VALUE_W'(got.fill_count), VALUE_W'(want.fill_count));
  endtask

  // reply side: check every accepted reply, stall in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        check_reply(deq_reply_t'(m_axis_tdata));
      end
      if (idle_on && stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = 0;
        m_axis_tready <= 1'b1;
      end
    end
  end

  // request side and end of run
  initial begin
    int unsigned phase_left;
    int unsigned phase_kind;
    int unsigned push_pct;
    int unsigned drain;
    logic [CMD_W-1:0] cmd;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    idle_on = 1'b1;
    mismatch_count = 0;
    shadow_front = '0;
    shadow_count = '0;
    phase_left = 0;
    phase_kind = PHASE_MIXED;
    push_pct = 40;

    // every read command and a spare code on an empty deque
    add_row(CMD_POP_FRONT,  32'h0000_0000, 1'b1, make_reply('0, ST_EMPTY, 1'b1, 5'd0));
    add_row(CMD_POP_BACK,   32'hFFFF_FFFF, 1'b1, make_reply('0, ST_EMPTY, 1'b1, 5'd0));
    add_row(CMD_PEEK_FRONT, 32'h0000_0000, 1'b1, make_reply('0, ST_EMPTY, 1'b1, 5'd0));
    add_row(CMD_PEEK_BACK,  32'hFFFF_FFFF, 1'b1, make_reply('0, ST_EMPTY, 1'b1, 5'd0));
    add_row(CMD_SPARE_7,    32'hFFFF_FFFF, 1'b1, make_reply('0, ST_OK,    1'b1, 5'd0));
    // fill to capacity from both ends
    add_row(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(CMD_PUSH_BACK,  32'h0000_0000, 1'b0, '0);
    add_row(CMD_PUSH_FRONT, 32'h8000_0000, 1'b0, '0);
    add_row(CMD_PUSH_BACK,  32'h0000_0001, 1'b0, '0);
    add_row(CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0);
    add_row(CMD_PUSH_BACK,  32'h5555_5555, 1'b0, '0);
    add_row(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(CMD_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, '0);
    add_row(CMD_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, '0);
    add_row(CMD_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, '0);
    add_row(CMD_PUSH_FRONT, 32'h0000_FFFF, 1'b0, '0);
    add_row(CMD_PUSH_BACK,  32'hFFFF_0000, 1'b0, '0);
    add_row(CMD_PUSH_FRONT, 32'h1234_5678, 1'b0, '0);
    add_row(CMD_PUSH_BACK,  32'h8765_4321, 1'b0, '0);
    add_row(CMD_PUSH_FRONT, 32'h00FF_00FF, 1'b0, '0);
    add_row(CMD_PUSH_BACK,  32'hFF00_FF00, 1'b0, '0);
    // pushes on a full deque are dropped
    add_row(CMD_PUSH_FRONT, 32'hCAFE_F00D, 1'b1, make_reply('0, ST_FULL, 1'b0, 5'd16));
    add_row(CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, make_reply('0, ST_FULL, 1'b0, 5'd16));
    add_row(CMD_SPARE_6,    32'h0000_0000, 1'b1, make_reply('0, ST_OK,   1'b0, 5'd16));
    // reads at both ends of the full ring
    add_row(CMD_PEEK_FRONT, 32'h0000_0000, 1'b0, '0);
    add_row(CMD_PEEK_BACK,  32'h0000_0000, 1'b0, '0);
    add_row(CMD_POP_BACK,   32'h0000_0000, 1'b0, '0);
    add_row(CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0);

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // random requests in fill, drain and mixed phases
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      idle_on = !((n >= 300 && n < 380) || n >= 700);
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        phase_kind = $urandom_range(PHASE_FILL, PHASE_MIXED);
        case (phase_kind)
          PHASE_FILL:  push_pct = 65;
          PHASE_DRAIN: push_pct = 20;
          default:     push_pct = 40;
        endcase
      end
      phase_left--;
      cmd = pick_command(push_pct);
      send_request(cmd, pick_word(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // wait for outstanding replies, then let the bench settle to catch stray ones
    drain = 0;
    while (pending_replies.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      flag_mismatch("replies never delivered", VALUE_W'(pending_replies.size()), '0);
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
